// ----- hdl/hcs_pkg.sv -----
// shared types and constants of the histogram chi2 swap engine
`default_nettype none
package hcs_pkg;
   localparam int NUM_BINS_MAX = 64;
   localparam int BIN_W        = $clog2(NUM_BINS_MAX);
   localparam int NACT_W       = BIN_W + 1;
   localparam int CNT_W        = 16;
   localparam int TGT_W        = 16;
   localparam int WT_W         = 24;
   localparam int ISC_W        = 25;
   localparam int FRAC_W       = CNT_W + ISC_W;
   localparam int CHI2_W       = 48;
   localparam int CSR_IDX_W    = 3;
   localparam int CSR_DATA_W   = 32;

   typedef enum logic [1:0] {
      MODE_LOAD    = 2'd0,
      MODE_ADD     = 2'd1,
      MODE_PROPOSE = 2'd2,
      MODE_COMMIT  = 2'd3
   } mode_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_LOWEST_EDGE  = 3'd0,
      CSR_HIGHEST_EDGE = 3'd1,
      CSR_INV_WIDTH    = 3'd2,
      CSR_BINS_IN_USE  = 3'd3,
      CSR_INV_SAMPLES  = 3'd4,
      CSR_INV_SIGMA2   = 3'd5
   } csr_index_type;

   // one histogram bin as it travels around the ring
   typedef struct packed {
      logic [CNT_W-1:0] count;
      logic [TGT_W-1:0] target;
      logic [WT_W-1:0]  weight;
   } entry_type;

   // edit applied at the head of the ring during one rotation
   typedef struct packed {
      mode_type         mode;
      logic             apply_swap;
      logic             same_bin;
      logic [BIN_W-1:0] add_bin;
      logic [BIN_W-1:0] remove_bin;
      logic [BIN_W-1:0] load_bin;
      logic [TGT_W-1:0] target;
      logic [WT_W-1:0]  weight;
   } edit_type;
endpackage
`default_nettype wire

// ----- hdl/hcs_req_if.sv -----
// request channel carrying one engine command
`default_nettype none
interface hcs_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  mode;
   logic [31:0] value_remove;
   logic [31:0] value_add;
   logic [5:0]  bin_index;
   logic [15:0] target_fraction;
   logic [23:0] bin_weight;

   modport source (output valid, mode, value_remove, value_add, bin_index,
                   target_fraction, bin_weight, input ready);
   modport sink (input valid, mode, value_remove, value_add, bin_index,
                 target_fraction, bin_weight, output ready);
endinterface
`default_nettype wire

// ----- hdl/hcs_rsp_if.sv -----
// response channel carrying one chi2 result
`default_nettype none
interface hcs_rsp_if;
   logic        valid;
   logic        ready;
   logic [47:0] chi2;
   logic [5:0]  add_bin;
   logic [5:0]  remove_bin;
   logic        count_underflow;

   modport source (output valid, chi2, add_bin, remove_bin, count_underflow,
                   input ready);
   modport sink (input valid, chi2, add_bin, remove_bin, count_underflow,
                 output ready);
endinterface
`default_nettype wire

// ----- hdl/hcs_cell.sv -----
// one ring cell holding a bin entry and passing it on each shift
`default_nettype none
module hcs_cell (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              shift,
   input  wire hcs_pkg::entry_type d,
   output hcs_pkg::entry_type     q
);
   import hcs_pkg::*;

   entry_type entry_ff;

   // reset empties the bin, otherwise take the neighbor's entry while the ring rotates
   always_ff @(posedge clock) begin
      if (reset) begin
         entry_ff.count <= '0;
      end else if (shift) begin
         entry_ff <= d;
      end
   end

   assign q = entry_ff;
endmodule
`default_nettype wire

// ----- hdl/hcs_binner.sv -----
// maps a Q16.16 value to a histogram bin, product registered
`default_nettype none
module hcs_binner (
   input  wire logic                      clock,
   input  wire logic                      enable,
   input  wire logic signed [31:0]        value,
   input  wire logic signed [31:0]        lowest_edge,
   input  wire logic signed [31:0]        highest_edge,
   input  wire logic [31:0]               inv_bin_width,
   input  wire logic [hcs_pkg::BIN_W-1:0] last_bin,
   output logic [hcs_pkg::BIN_W-1:0]      bin
);
   import hcs_pkg::*;

   logic        below_ff;
   logic        above_ff;
   logic [63:0] prod_ff;
   logic [32:0] offset;
   logic [31:0] idx;

   assign offset = 33'(value) - 33'(lowest_edge);

   // compare and scale by the inverse width
   always_ff @(posedge clock) begin
      if (enable) begin
         below_ff <= value < lowest_edge;
         above_ff <= highest_edge < value;
         prod_ff  <= 64'(offset[31:0]) * 64'(inv_bin_width);
      end
   end

   // clamp into the active range
   assign idx = prod_ff[63:32];
   always_comb begin
      priority if (below_ff) begin
         bin = '0;
      end else if (above_ff || idx > 32'(last_bin)) begin
         bin = last_bin;
      end else begin
         bin = idx[BIN_W-1:0];
      end
   end
endmodule
`default_nettype wire

// ----- hdl/hcs_update.sv -----
// edits the entry at the head of the ring and gives its effective count
`default_nettype none
module hcs_update (
   input  wire hcs_pkg::entry_type        head,
   input  wire logic [hcs_pkg::BIN_W-1:0] pos,
   input  wire hcs_pkg::edit_type         edit,
   output hcs_pkg::entry_type             wb,
   output logic [hcs_pkg::CNT_W-1:0]      eff_count,
   output logic                           uf_hit
);
   import hcs_pkg::*;

   logic [CNT_W-1:0] inc;

   assign inc = (&head.count) ? head.count : head.count + 1'b1;

   always_comb begin
      wb        = head;
      eff_count = head.count;
      uf_hit    = 1'b0;
      unique case (edit.mode)
         MODE_LOAD: begin
            if (pos == edit.load_bin) begin
               wb.count  = '0;
               wb.target = edit.target;
               wb.weight = edit.weight;
            end
         end
         MODE_ADD: begin
            if (pos == edit.add_bin) begin
               eff_count = inc;
            end
            wb.count = eff_count;
         end
         MODE_PROPOSE, MODE_COMMIT: begin
            // swap within one bin leaves the count alone
            if (edit.apply_swap && !edit.same_bin) begin
               if (pos == edit.add_bin) begin
                  eff_count = inc;
               end else if (pos == edit.remove_bin) begin
                  if (head.count == '0) begin
                     uf_hit = 1'b1;
                  end else begin
                     eff_count = head.count - 1'b1;
                  end
               end
            end
            if (edit.mode == MODE_COMMIT && edit.apply_swap) begin
               wb.count = eff_count;
            end
         end
         default: begin
            wb = head;
         end
      endcase
   end
endmodule
`default_nettype wire

// ----- hdl/hcs_term.sv -----
// three-stage pipeline computing one weighted squared deviation
`default_nettype none
module hcs_term (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      active,
   input  wire logic [hcs_pkg::CNT_W-1:0] count,
   input  wire logic [hcs_pkg::TGT_W-1:0] target,
   input  wire logic [hcs_pkg::WT_W-1:0]  weight,
   input  wire logic [hcs_pkg::ISC_W-1:0] inv_samples,
   output logic [63:0]                    term
);
   import hcs_pkg::*;

   logic              act1_ff, act2_ff;
   logic [FRAC_W-1:0] frac_ff;
   logic [TGT_W-1:0]  tgt1_ff;
   logic [WT_W-1:0]   wt1_ff, wt2_ff;
   logic [63:0]       sq_ff;
   logic [63:0]       term_ff;
   logic [FRAC_W-1:0] tgt_wide;
   logic [FRAC_W-1:0] mag;
   logic [31:0]       mag_sat;

   // stage valid flags
   always_ff @(posedge clock) begin
      if (reset) begin
         act1_ff <= 1'b0;
         act2_ff <= 1'b0;
      end else begin
         act1_ff <= active;
         act2_ff <= act1_ff;
      end
   end

   // fraction of samples in the bin
   always_ff @(posedge clock) begin
      frac_ff <= FRAC_W'(count) * FRAC_W'(inv_samples);
      tgt1_ff <= target;
      wt1_ff  <= weight;
   end

   // deviation magnitude, saturated, then squared
   assign tgt_wide = FRAC_W'({tgt1_ff, 8'd0});
   assign mag      = (frac_ff >= tgt_wide) ? frac_ff - tgt_wide : tgt_wide - frac_ff;
   assign mag_sat  = (|mag[FRAC_W-1:32]) ? 32'hFFFF_FFFF : mag[31:0];

   always_ff @(posedge clock) begin
      sq_ff  <= 64'(mag_sat) * 64'(mag_sat);
      wt2_ff <= wt1_ff;
   end

   // weight the square, inactive bins add nothing
   always_ff @(posedge clock) begin
      if (reset) begin
         term_ff <= '0;
      end else begin
         term_ff <= act2_ff ? 64'(sq_ff[63:24]) * 64'(wt2_ff) : 64'd0;
      end
   end

   assign term = term_ff;
endmodule
`default_nettype wire

// ----- hdl/histogram_chi2_swap_engine.sv -----
// top level: configuration, command sequencer, bin ring and chi2 scaling
//
//  channel  dir  handshake          payload
//  req_bus  in   valid/ready        mode, values, bin entry fields
//  rsp_bus  out  valid/ready        chi2, add_bin, remove_bin, count_underflow
//  csr_*    in   csr_we             csr_index, csr_wdata
//
//  Every transaction runs from acceptance to the response register while
//  the bin ring makes one full turn, one bin per cycle past the shared term
//  pipeline, followed by the drain and scale steps.
//  Reset clears all counts and control state at once; no clearing pass.
//  A new request is taken while a finished response still waits; a stalled
//  response holds the sequencer in its final step.
`default_nettype none
module histogram_chi2_swap_engine (
   input  wire logic                           clock,
   input  wire logic                           reset,
   hcs_req_if.sink                             req_bus,
   hcs_rsp_if.source                           rsp_bus,
   input  wire logic                           csr_we,
   input  wire logic [hcs_pkg::CSR_IDX_W-1:0]  csr_index,
   input  wire logic [hcs_pkg::CSR_DATA_W-1:0] csr_wdata
);
   import hcs_pkg::*;

   typedef enum logic [2:0] {
      ST_IDLE, ST_BIN, ST_SPIN, ST_DRAIN, ST_SCALE, ST_FINISH
   } state_type;

   // configuration registers
   logic signed [31:0] lowest_ff, highest_ff;
   logic [31:0]        inv_width_ff, inv_sigma_ff;
   logic [6:0]         bins_ff;
   logic [ISC_W-1:0]   inv_samples_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         lowest_ff      <= '0;
         highest_ff     <= '0;
         inv_width_ff   <= 32'd65536;
         bins_ff        <= 7'd64;
         inv_samples_ff <= 25'd16777216;
         inv_sigma_ff   <= 32'd65536;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_LOWEST_EDGE:  lowest_ff      <= csr_wdata;
            CSR_HIGHEST_EDGE: highest_ff     <= csr_wdata;
            CSR_INV_WIDTH:    inv_width_ff   <= csr_wdata;
            CSR_BINS_IN_USE:  bins_ff        <= csr_wdata[6:0];
            CSR_INV_SAMPLES:  inv_samples_ff <= csr_wdata[ISC_W-1:0];
            CSR_INV_SIGMA2:   inv_sigma_ff   <= csr_wdata;
            default:          inv_sigma_ff   <= inv_sigma_ff;
         endcase
      end
   end

   // active bin count clamped between 2 and the ring size
   logic [NACT_W-1:0] nact;
   logic [BIN_W-1:0]  last_bin;
   always_comb begin
      priority if (int'(bins_ff) < 2) begin
         nact = NACT_W'(2);
      end else if (int'(bins_ff) > NUM_BINS_MAX) begin
         nact = NACT_W'(NUM_BINS_MAX);
      end else begin
         nact = NACT_W'(bins_ff);
      end
   end
   assign last_bin = BIN_W'(nact - 1'b1);

   // sequencer and control state
   state_type         state_ff;
   logic [BIN_W-1:0]  pos_ff;
   logic [1:0]        drain_ff;
   logic              pend_ff;
   logic [BIN_W-1:0]  pend_ab_ff, pend_rb_ff;
   logic [CHI2_W-1:0] committed_ff, trial_ff;
   logic              uf_ff;
   logic [63:0]       sum_ff;
   logic              rsp_valid_ff;
   logic [CHI2_W-1:0] rsp_chi2_ff;
   logic [5:0]        rsp_ab_ff, rsp_rb_ff;
   logic              rsp_uf_ff;

   // latched command
   mode_type          op_mode_ff;
   logic [31:0]       op_vr_ff, op_va_ff;
   logic [BIN_W-1:0]  op_bi_ff;
   logic [TGT_W-1:0]  op_tgt_ff;
   logic [WT_W-1:0]   op_wt_ff;

   logic req_take;
   logic fin_go;
   assign req_take = req_bus.valid && req_bus.ready;
   assign req_bus.ready = (state_ff == ST_IDLE);
   assign fin_go = (state_ff == ST_FINISH) && (!rsp_valid_ff || rsp_bus.ready);

   always_ff @(posedge clock) begin
      if (req_take) begin
         op_mode_ff <= mode_type'(req_bus.mode);
         op_vr_ff   <= req_bus.value_remove;
         op_va_ff   <= req_bus.value_add;
         op_bi_ff   <= BIN_W'(req_bus.bin_index);
         op_tgt_ff  <= req_bus.target_fraction;
         op_wt_ff   <= req_bus.bin_weight;
      end
   end

   // bin lookup for both values
   logic [BIN_W-1:0] bin_r, bin_a;
   logic             bin_en;
   assign bin_en = (state_ff == ST_BIN);

   hcs_binner u_bin_remove (
      .clock(clock), .enable(bin_en), .value(op_vr_ff),
      .lowest_edge(lowest_ff), .highest_edge(highest_ff),
      .inv_bin_width(inv_width_ff), .last_bin(last_bin), .bin(bin_r)
   );

   hcs_binner u_bin_add (
      .clock(clock), .enable(bin_en), .value(op_va_ff),
      .lowest_edge(lowest_ff), .highest_edge(highest_ff),
      .inv_bin_width(inv_width_ff), .last_bin(last_bin), .bin(bin_a)
   );

   // edit for this rotation
   edit_type edit;
   always_comb begin
      edit.mode       = op_mode_ff;
      edit.apply_swap = (op_mode_ff == MODE_PROPOSE) ||
                        (op_mode_ff == MODE_COMMIT && pend_ff);
      edit.add_bin    = (op_mode_ff == MODE_COMMIT) ? pend_ab_ff : bin_a;
      edit.remove_bin = (op_mode_ff == MODE_COMMIT) ? pend_rb_ff : bin_r;
      edit.same_bin   = (edit.add_bin == edit.remove_bin);
      edit.load_bin   = op_bi_ff;
      edit.target     = op_tgt_ff;
      edit.weight     = op_wt_ff;
   end

   // ring of bin cells, head is cell 0, edited head re-enters at the tail
   entry_type        cell_q [NUM_BINS_MAX];
   entry_type        wb;
   logic [CNT_W-1:0] eff_count;
   logic             uf_hit;
   logic             spin;
   assign spin = (state_ff == ST_SPIN);

   hcs_update u_update (
      .head(cell_q[0]), .pos(pos_ff), .edit(edit),
      .wb(wb), .eff_count(eff_count), .uf_hit(uf_hit)
   );

   for (genvar k = 0; k < NUM_BINS_MAX; k++) begin : g_ring
      entry_type d;
      if (k == NUM_BINS_MAX - 1) begin : g_tail
         assign d = wb;
      end else begin : g_mid
         assign d = cell_q[k+1];
      end
      hcs_cell u_cell (
         .clock(clock), .reset(reset), .shift(spin), .d(d), .q(cell_q[k])
      );
   end

   // weighted deviation of the head bin
   logic [63:0] term;
   logic        act;
   assign act = spin && ({1'b0, pos_ff} < nact);

   hcs_term u_term (
      .clock(clock), .reset(reset), .active(act),
      .count(eff_count),
      .target(cell_q[0].target), .weight(cell_q[0].weight),
      .inv_samples(inv_samples_ff), .term(term)
   );

   // saturating accumulation and the final scale
   logic [64:0] sum_wide;
   logic [63:0] phi_ff, plo_ff;
   logic [64:0] scaled;
   logic [56:0] r_full;
   logic [CHI2_W-1:0] r_chi2;
   assign sum_wide = {1'b0, sum_ff} + {1'b0, term};
   assign scaled   = {1'b0, phi_ff} + 65'(plo_ff[63:32]);
   assign r_full   = scaled[64:8];
   assign r_chi2   = (|r_full[56:CHI2_W]) ? {CHI2_W{1'b1}} : r_full[CHI2_W-1:0];

   always_ff @(posedge clock) begin
      if (state_ff == ST_BIN) begin
         sum_ff <= '0;
      end else if (state_ff == ST_SPIN || state_ff == ST_DRAIN) begin
         sum_ff <= sum_wide[64] ? 64'hFFFF_FFFF_FFFF_FFFF : sum_wide[63:0];
      end
      if (state_ff == ST_SCALE) begin
         phi_ff <= 64'(sum_ff[63:32]) * 64'(inv_sigma_ff);
         plo_ff <= 64'(sum_ff[31:0]) * 64'(inv_sigma_ff);
      end
   end

   // sequencer, engine state and response register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         pos_ff       <= '0;
         drain_ff     <= '0;
         pend_ff      <= 1'b0;
         pend_ab_ff   <= '0;
         pend_rb_ff   <= '0;
         committed_ff <= '0;
         trial_ff     <= '0;
         uf_ff        <= 1'b0;
         rsp_valid_ff <= 1'b0;
         rsp_chi2_ff  <= '0;
         rsp_ab_ff    <= '0;
         rsp_rb_ff    <= '0;
         rsp_uf_ff    <= 1'b0;
      end else begin
         if (rsp_valid_ff && rsp_bus.ready) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            ST_IDLE: begin
               if (req_take) begin
                  state_ff <= ST_BIN;
               end
            end
            ST_BIN: begin
               uf_ff    <= 1'b0;
               pos_ff   <= '0;
               state_ff <= ST_SPIN;
            end
            ST_SPIN: begin
               if (uf_hit) begin
                  uf_ff <= 1'b1;
               end
               pos_ff <= pos_ff + 1'b1;
               if (pos_ff == BIN_W'(NUM_BINS_MAX - 1)) begin
                  drain_ff <= '0;
                  state_ff <= ST_DRAIN;
               end
            end
            ST_DRAIN: begin
               drain_ff <= drain_ff + 1'b1;
               if (drain_ff == 2'd2) begin
                  state_ff <= ST_SCALE;
               end
            end
            ST_SCALE: begin
               state_ff <= ST_FINISH;
            end
            ST_FINISH: begin
               if (fin_go) begin
                  state_ff     <= ST_IDLE;
                  rsp_valid_ff <= 1'b1;
                  rsp_chi2_ff  <= committed_ff;
                  rsp_ab_ff    <= '0;
                  rsp_rb_ff    <= '0;
                  rsp_uf_ff    <= 1'b0;
                  unique case (op_mode_ff)
                     MODE_LOAD: begin
                        pend_ff <= 1'b0;
                     end
                     MODE_ADD: begin
                        pend_ff      <= 1'b0;
                        committed_ff <= r_chi2;
                        rsp_chi2_ff  <= r_chi2;
                        rsp_ab_ff    <= 6'(edit.add_bin);
                     end
                     MODE_PROPOSE: begin
                        pend_ff     <= 1'b1;
                        pend_ab_ff  <= edit.add_bin;
                        pend_rb_ff  <= edit.remove_bin;
                        trial_ff    <= r_chi2;
                        rsp_chi2_ff <= r_chi2;
                        rsp_ab_ff   <= 6'(edit.add_bin);
                        rsp_rb_ff   <= 6'(edit.remove_bin);
                        rsp_uf_ff   <= uf_ff;
                     end
                     MODE_COMMIT: begin
                        if (pend_ff) begin
                           pend_ff      <= 1'b0;
                           committed_ff <= trial_ff;
                           rsp_chi2_ff  <= trial_ff;
                           rsp_ab_ff    <= 6'(pend_ab_ff);
                           rsp_rb_ff    <= 6'(pend_rb_ff);
                           rsp_uf_ff    <= uf_ff;
                        end
                     end
                     default: begin
                        pend_ff <= pend_ff;
                     end
                  endcase
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   assign rsp_bus.valid           = rsp_valid_ff;
   assign rsp_bus.chi2            = rsp_chi2_ff;
   assign rsp_bus.add_bin         = rsp_ab_ff;
   assign rsp_bus.remove_bin      = rsp_rb_ff;
   assign rsp_bus.count_underflow = rsp_uf_ff;

   // ring makes exactly one full turn per transaction
   a_ring_turn: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SPIN && pos_ff == BIN_W'(NUM_BINS_MAX - 1))
      |=> (state_ff == ST_DRAIN && pos_ff == '0))
      else $error("ring rotation did not end after a full turn");

   // load and add cancel any pending swap
   a_cancel_swap: assert property (@(posedge clock) disable iff (reset)
      (fin_go && (op_mode_ff == MODE_LOAD || op_mode_ff == MODE_ADD)) |=> !pend_ff)
      else $error("pending swap survived a load or add");

   // load and add never report a removal
   a_no_remove: assert property (@(posedge clock) disable iff (reset)
      (fin_go && (op_mode_ff == MODE_LOAD || op_mode_ff == MODE_ADD))
      |=> (!rsp_bus.count_underflow && rsp_bus.remove_bin == '0))
      else $error("removal reported for a load or add");
endmodule
`default_nettype wire
